// File: design/cwrt_pkg.sv
// Shared types and constants for the code write region tracker.
`timescale 1ns / 1ps

package cwrt_pkg;

    localparam int MAX_REGIONS_DEF = 16;

    localparam logic [31:0] WIN_ITCM_END = 32'h0000_8000;
    localparam logic [31:0] WIN_DTCM_LO  = 32'h027E_0000;
    localparam logic [31:0] WIN_DTCM_HI  = 32'h027E_4000;
    localparam logic [31:0] WIN_MAIN_LO  = 32'h0200_0000;
    localparam logic [31:0] WIN_MAIN_HI  = 32'h0240_0000;
    localparam logic [15:0] SLACK_RESET  = 16'h1000;

    typedef enum logic [1:0] {
        ACT_IGNORED = 2'd0,
        ACT_MERGED  = 2'd1,
        ACT_NEW     = 2'd2,
        ACT_FULL    = 2'd3
    } action_t;

    typedef struct packed {
        logic [31:0] origin;
        logic [31:0] hits;
        logic [31:0] len;
        logic [31:0] base;
    } region_t;

    // Compare result for one stored region
    typedef struct packed {
        logic hit;       // write joins this region
        logic start_in;  // write starts in or near the region (else region follows write)
    } match_t;

endpackage

// File: design/cwrt_region_mem.sv
// Region table storage: one write port, one registered read port.
`timescale 1ns / 1ps

module cwrt_region_mem
    import cwrt_pkg::*;
#(
    parameter int DEPTH  = MAX_REGIONS_DEF,
    parameter int ADDR_W = 4
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  region_t           wdata,
    input  logic [ADDR_W-1:0] raddr,
    output region_t           rdata
);

    region_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/cwrt_match_unit.sv
// Shared compare unit: tests one stored region against the current write.
`timescale 1ns / 1ps

module cwrt_match_unit
    import cwrt_pkg::*;
(
    input  region_t     entry,
    input  logic [31:0] wr_addr,
    input  logic [31:0] wr_endk,   // addr + len + slack, wrapped
    input  logic [15:0] slack,
    output match_t      result
);

    logic [31:0] near_end;
    logic        in_hit;
    logic        front_hit;

    always_comb
    begin
        near_end  = entry.base + entry.len + {16'd0, slack};
        in_hit    = (wr_addr >= entry.base) && (wr_addr < near_end);
        front_hit = (entry.base >= wr_addr) && (entry.base < wr_endk);
        result.hit      = in_hit || front_hit;
        result.start_in = in_hit;
    end

endmodule

// File: design/code_write_region_tracker.sv
// Top level: request sequencer, region scan and result register.
//
// Usage:
//   s_axis carries one memory write request (address, length, source tag).
//   m_axis returns exactly one result per request: action, touched slot,
//   the slot's region after update and the generation count.
//   cfg_* writes merge_slack; it is always ready and should be written only
//   while no request is in flight.
//   A request passes through a filter step, one compare per stored region
//   (up to MAX_REGIONS, stopping at the first match), an update step and
//   the load of the result register; a write outside the windows skips
//   the scan and the update. The scan goes one entry per cycle through the
//   shared compare unit. s_axis_tready is high only while the sequencer is
//   idle, so a new request is not taken until the last one's result has
//   been loaded into the output register.
//   A finished result sits in the output register; the next request is taken
//   while it waits, but that request's result holds in the sequencer until
//   the receiver takes the previous one.
//   Reset empties the table, clears the generation count and sets
//   merge_slack to 4096. The region memory itself is not cleared.
`timescale 1ns / 1ps

module code_write_region_tracker
    import cwrt_pkg::*;
#(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data,       // merge_slack

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // write_addr, write_len, source_tag

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [167:0] m_axis_tdata    // action, slot_index, region_base,
                                         // region_len, region_hits,
                                         // region_origin, current_generation, pad
);

    localparam int SLOT_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W  = $clog2(MAX_REGIONS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILTER,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [15:0]         slack_reg;
    logic [CNT_W-1:0]    used_reg;
    logic [31:0]         gen_reg;
    logic [31:0]         gen_next;
    logic [SLOT_W-1:0]   scan_idx_reg;

    logic [31:0]         addr_reg;
    logic [31:0]         len_reg;
    logic [31:0]         tag_reg;
    logic [31:0]         wr_end_reg;
    logic [31:0]         wr_endk_reg;

    logic                hit_reg;
    logic                start_in_reg;
    region_t             hold_reg;

    action_t             res_action_reg;
    logic [3:0]          res_slot_reg;
    region_t             res_entry_reg;

    logic                out_valid_reg;
    logic [167:0]        out_data_reg;

    region_t             rd_data;
    logic [SLOT_W-1:0]   rd_addr;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_waddr;
    region_t             mem_wdata;
    match_t              match;

    logic                in_window;
    logic                last_scan;
    logic                table_full;
    logic                out_load;
    logic [31:0]         merged_end;
    logic [31:0]         hold_end;
    logic [SLOT_W-1:0]   used_slot;
    logic [SLOT_W+3:0]   slot_wide;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    cwrt_region_mem #(
        .DEPTH  (MAX_REGIONS),
        .ADDR_W (SLOT_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    cwrt_match_unit u_match (
        .entry   (rd_data),
        .wr_addr (addr_reg),
        .wr_endk (wr_endk_reg),
        .slack   (slack_reg),
        .result  (match)
    );

    always_comb
    begin
        in_window = (addr_reg < WIN_ITCM_END)
                 || ((addr_reg >= WIN_DTCM_LO) && (addr_reg < WIN_DTCM_HI))
                 || ((addr_reg >= WIN_MAIN_LO) && (addr_reg < WIN_MAIN_HI));

        gen_next = gen_reg + 32'd1;
        if (gen_next == 32'd0)
        begin
            gen_next = 32'd1;
        end

        last_scan  = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == used_reg);
        table_full = (used_reg >= CNT_W'(MAX_REGIONS));
        used_slot  = used_reg[SLOT_W-1:0];
        out_load   = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

        // Read next entry while the current one is compared
        rd_addr = '0;
        if (state_reg == ST_SCAN)
        begin
            rd_addr = scan_idx_reg + SLOT_W'(1);
        end

        hold_end   = hold_reg.base + hold_reg.len;
        merged_end = (hold_end > wr_end_reg) ? hold_end : wr_end_reg;

        mem_wdata = hold_reg;
        if (hit_reg)
        begin
            mem_waddr      = scan_idx_reg;
            mem_wdata.hits = hold_reg.hits + 32'd1;
            if (start_in_reg)
            begin
                mem_wdata.len = merged_end - hold_reg.base;
            end
            else
            begin
                mem_wdata.base = addr_reg;
                mem_wdata.len  = merged_end - addr_reg;
            end
        end
        else
        begin
            mem_waddr        = used_slot;
            mem_wdata.base   = addr_reg;
            mem_wdata.len    = len_reg;
            mem_wdata.hits   = 32'd1;
            mem_wdata.origin = tag_reg;
        end
        mem_we = (state_reg == ST_UPDATE) && (hit_reg || !table_full);

        slot_wide = {4'd0, mem_waddr};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slack_reg      <= SLACK_RESET;
            used_reg       <= '0;
            gen_reg        <= '0;
            scan_idx_reg   <= '0;
            addr_reg       <= '0;
            len_reg        <= '0;
            tag_reg        <= '0;
            wr_end_reg     <= '0;
            wr_endk_reg    <= '0;
            hit_reg        <= 1'b0;
            start_in_reg   <= 1'b0;
            hold_reg       <= '0;
            res_action_reg <= ACT_IGNORED;
            res_slot_reg   <= '0;
            res_entry_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                slack_reg <= cfg_data;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        addr_reg   <= s_axis_tdata[31:0];
                        len_reg    <= s_axis_tdata[63:32];
                        tag_reg    <= s_axis_tdata[95:64];
                        wr_end_reg <= s_axis_tdata[31:0] + s_axis_tdata[63:32];
                        state_reg  <= ST_FILTER;
                    end
                end

                ST_FILTER:
                begin
                    scan_idx_reg <= '0;
                    hit_reg      <= 1'b0;
                    wr_endk_reg  <= wr_end_reg + {16'd0, slack_reg};
                    if (!in_window)
                    begin
                        res_action_reg <= ACT_IGNORED;
                        res_slot_reg   <= '0;
                        res_entry_reg  <= '0;
                        state_reg      <= ST_DONE;
                    end
                    else
                    begin
                        gen_reg <= gen_next;
                        if (used_reg == '0)
                        begin
                            state_reg <= ST_UPDATE;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end

                ST_SCAN:
                begin
                    if (match.hit)
                    begin
                        hit_reg      <= 1'b1;
                        start_in_reg <= match.start_in;
                        hold_reg     <= rd_data;
                        state_reg    <= ST_UPDATE;
                    end
                    else if (last_scan)
                    begin
                        state_reg <= ST_UPDATE;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
                    end
                end

                ST_UPDATE:
                begin
                    if (hit_reg)
                    begin
                        res_action_reg <= ACT_MERGED;
                        res_slot_reg   <= slot_wide[3:0];
                        res_entry_reg  <= mem_wdata;
                    end
                    else if (table_full)
                    begin
                        res_action_reg <= ACT_FULL;
                        res_slot_reg   <= '0;
                        res_entry_reg  <= '0;
                    end
                    else
                    begin
                        res_action_reg <= ACT_NEW;
                        res_slot_reg   <= slot_wide[3:0];
                        res_entry_reg  <= mem_wdata;
                        used_reg       <= used_reg + CNT_W'(1);
                    end
                    state_reg <= ST_DONE;
                end

                ST_DONE:
                begin
                    // Wait for the output register to free up
                    if (out_load)
                    begin
                        out_data_reg  <= {2'b00, gen_reg, res_entry_reg.origin,
                                          res_entry_reg.hits, res_entry_reg.len,
                                          res_entry_reg.base, res_slot_reg,
                                          res_action_reg};
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: dv/code_write_region_tracker_test.sv
// Self-checking testbench for the code write region tracker.
`timescale 1ns / 1ps

module code_write_region_tracker_test;
    import cwrt_pkg::*;

    localparam int SCAN_LATENCY  = MAX_REGIONS_DEF + 3;
    localparam int QUIET_LIMIT   = 3000;
    localparam int RECV_HOLD     = 400;
    localparam int PHASES        = 6;
    localparam int PHASE_WRITES  = 180;

    // Field layout of m_axis_tdata, lowest bits at the bottom
    typedef struct packed {
        logic [1:0]  pad;
        logic [31:0] generation;
        logic [31:0] origin;
        logic [31:0] hits;
        logic [31:0] len;
        logic [31:0] base;
        logic [3:0]  slot;
        action_t     act;
    } tracker_result_t;

    localparam logic [31:0] WINDOW_BOUNDS [11] = '{
        32'h0000_0000, 32'h0000_7FFF, 32'h0000_8000, 32'h027D_FFFF, 32'h027E_0000,
        32'h027E_3FFF, 32'h027E_4000, 32'h01FF_FFFF, 32'h0200_0000, 32'h023F_FFFF,
        32'h0240_0000
    };

    localparam logic [31:0] DIR_ADDR [20] = '{
        32'h0000_8000, 32'h027D_FFFF, 32'h027E_4000, 32'h01FF_FFFF, 32'h0240_0000,
        32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_7FFF, 32'h0000_0100, 32'h027E_0000,
        32'h027E_3FFF, 32'h0200_0000, 32'h023F_FFFF, 32'h0200_3000, 32'h0200_1800,
        32'h0000_7000, 32'h0000_7800, 32'h027E_0100, 32'h0200_0000, 32'h023F_F000
    };
    localparam logic [31:0] DIR_LEN [20] = '{
        32'h0000_0004, 32'h0000_0001, 32'h0000_0008, 32'h0000_0010, 32'h0000_0020,
        32'hFFFF_FFFF, 32'h0000_0010, 32'h0000_0001, 32'h0000_0020, 32'h0000_0100,
        32'h0000_0000, 32'h0000_0008, 32'h0000_0000, 32'h0000_0010, 32'h0000_0801,
        32'hFFFF_F000, 32'h0000_0004, 32'h0000_0010, 32'h0000_2000, 32'h0000_0800
    };

    // Mirror of the region table; predicts one result per write request
    class region_table_check;
        logic [31:0] base_q [MAX_REGIONS_DEF];
        logic [31:0] len_q [MAX_REGIONS_DEF];
        logic [31:0] hits_q [MAX_REGIONS_DEF];
        logic [31:0] origin_q [MAX_REGIONS_DEF];
        int unsigned used;
        logic [31:0] generation;
        logic [15:0] slack;
        tracker_result_t pending_outcomes [$];
        int errors;

        function new();
            used = 0;
            generation = '0;
            slack = SLACK_RESET;
            errors = 0;
        endfunction

        function void log_request(logic [31:0] a, logic [31:0] n, logic [31:0] tag);
            tracker_result_t r;
            logic [31:0] k, s, l, s_end, a_end, far;
            int hit_slot;
            r = '0;
            k = {16'h0, slack};
            hit_slot = -1;
            if (!(a < WIN_ITCM_END || (a >= WIN_DTCM_LO && a < WIN_DTCM_HI)
                  || (a >= WIN_MAIN_LO && a < WIN_MAIN_HI))) begin
                r.act = ACT_IGNORED;
                r.generation = generation;
                pending_outcomes.insert(pending_outcomes.size(), r);
                return;
            end
            generation = generation + 32'd1;
            if (generation == '0)
                generation = 32'd1;
            // First region in insertion order that touches the write wins
            for (int i = 0; i < used; i++) begin
                s = base_q[i];
                l = len_q[i];
                s_end = s + l;
                a_end = a + n;
                far = s_end + k;
                if (a >= s && a < far) begin
                    len_q[i] = ((s_end > a_end) ? s_end : a_end) - s;
                    hit_slot = i;
                    break;
                end
                far = a_end + k;
                if (s >= a && s < far) begin
                    base_q[i] = a;
                    len_q[i] = ((a_end > s_end) ? a_end : s_end) - a;
                    hit_slot = i;
                    break;
                end
            end
            if (hit_slot >= 0) begin
                hits_q[hit_slot] = hits_q[hit_slot] + 32'd1;
                r.act = ACT_MERGED;
            end else if (used >= MAX_REGIONS_DEF) begin
                r.act = ACT_FULL;
            end else begin
                hit_slot = used;
                base_q[hit_slot] = a;
                len_q[hit_slot] = n;
                hits_q[hit_slot] = 32'd1;
                origin_q[hit_slot] = tag;
                used++;
                r.act = ACT_NEW;
            end
            if (hit_slot >= 0) begin
                r.slot = hit_slot[3:0];
                r.base = base_q[hit_slot];
                r.len = len_q[hit_slot];
                r.hits = hits_q[hit_slot];
                r.origin = origin_q[hit_slot];
            end
            r.generation = generation;
            pending_outcomes.insert(pending_outcomes.size(), r);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            end
        endfunction

        function void check_result(tracker_result_t got);
            tracker_result_t want;
            if (pending_outcomes.size() == 0) begin
                errors++;
                $error("result with no request outstanding: action %0d", got.act);
                return;
            end
            want = pending_outcomes.pop_front();
            check_field("action", 32'(want.act), 32'(got.act));
            check_field("slot_index", 32'(want.slot), 32'(got.slot));
            check_field("region_base", want.base, got.base);
            check_field("region_len", want.len, got.len);
            check_field("region_hits", want.hits, got.hits);
            check_field("region_origin", want.origin, got.origin);
            check_field("current_generation", want.generation, got.generation);
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [15:0]  cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata = '0;    // write_addr, write_len, source_tag
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [167:0] m_axis_tdata;         // action, slot_index, region_base, region_len,
                                        // region_hits, region_origin, current_generation

    region_table_check sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_ask = 0;
    int quiet_cycles = 0;

    always #4 clk = ~clk;

    code_write_region_tracker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    task automatic write_slack(input logic [15:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.slack = value;
    endtask

    task automatic send_write(input logic [31:0] a, input logic [31:0] n,
                              input logic [31:0] tag);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= {tag, n, a};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.log_request(a, n, tag);
    endtask

    task automatic wait_drained();
        while (sb.pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Mostly writes aimed at existing regions and window space, some noise
    function automatic void pick_write(output logic [31:0] a, output logic [31:0] n,
                                       output logic [31:0] tag);
        int unsigned roll, j;
        logic [31:0] k, s, l;
        roll = $urandom_range(99);
        k = {16'h0, sb.slack};
        tag = $urandom;
        case ($urandom_range(9))
            0: n = $urandom;
            1: n = '0;
            default: n = $urandom_range(0, 32'h2000);
        endcase
        if (roll < 12) begin
            a = $urandom;
        end else if (roll < 20) begin
            a = WINDOW_BOUNDS[$urandom_range(10)];
        end else if (roll < 65 && sb.used > 0) begin
            j = $urandom_range(sb.used - 1);
            s = sb.base_q[j];
            l = sb.len_q[j];
            case ($urandom_range(2))
                0: a = s + l + k - 32'd8 + 32'($urandom_range(0, 16));
                1: a = s - 32'($urandom_range(0, int'(k) + 256));
                default: a = s + 32'($urandom_range(0, 1024));
            endcase
        end else begin
            case ($urandom_range(2))
                0: a = $urandom_range(0, WIN_ITCM_END - 1);
                1: a = $urandom_range(WIN_DTCM_LO, WIN_DTCM_HI - 1);
                default: a = $urandom_range(WIN_MAIN_LO, WIN_MAIN_HI - 1);
            endcase
        end
    endfunction

    // Result sink: checks every accepted result, random backpressure
    initial begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(tracker_result_t'(m_axis_tdata));
            if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                hold_left = RECV_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("code_write_region_tracker regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        logic [31:0] a, n, tag;
        logic [15:0] slack_val;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 25;
        recv_idle_pct = 79;
        write_slack(SLACK_RESET);

        // Window edges, wrapped sums, both merge directions
        for (int i = 0; i < 20; i++)
            send_write(DIR_ADDR[i], DIR_LEN[i], (i == 6) ? 32'h0 : ~32'(i));

        for (int p = 0; p < PHASES; p++) begin
            s_axis_tvalid <= 1'b0;
            wait_drained();
            repeat (SCAN_LATENCY) @(posedge clk);
            case (p)
                0: slack_val = 16'h0000;
                1: slack_val = 16'hFFFF;
                3: slack_val = 16'h0001;
                5: slack_val = SLACK_RESET;
                default: slack_val = 16'($urandom_range(0, 16'hFFFF));
            endcase
            write_slack(slack_val);
            if (p < 2) begin
                send_idle_pct = 25;
                recv_idle_pct = 79;
            end else if (p < 4) begin
                send_idle_pct = 79;
                recv_idle_pct = 25;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // long receiver stall while requests keep coming
            if (p == 1)
                hold_ask <= hold_ask + 1;
            for (int i = 0; i < PHASE_WRITES; i++) begin
                if (p == 2 && i == PHASE_WRITES / 2) begin
                    s_axis_tvalid <= 1'b0;
                    wait_drained();
                end
                pick_write(a, n, tag);
                send_write(a, n, tag);
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (2 * SCAN_LATENCY) @(posedge clk);
        if (sb.errors == 0 && sb.pending_outcomes.size() == 0)
            $display("code_write_region_tracker regression: pass");
        else
            $display("code_write_region_tracker regression: fail");
        $finish;
    end

endmodule
